// ----- rtl/core/ucdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ucdc_pkg
// Shared types and constants of the CDC ACM control request handler.
// ----------------------------------------------------------------------------
package ucdc_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_SETUP    = 2'd0,
    OP_OUT_DATA = 2'd1,
    OP_IN_DONE  = 2'd2
  } op_t;

  // Reply kinds carried on the output tuser
  typedef enum logic [1:0] {
    RK_NONE   = 2'd0,
    RK_STATUS = 2'd1,
    RK_DATA   = 2'd2
  } reply_kind_t;

  // Setup signatures {bmRequestType, bRequest}
  localparam logic [15:0] REQ_SET_LINE_CODING = 16'h2120;
  localparam logic [15:0] REQ_SET_CTRL_LINE   = 16'h2122;
  localparam logic [15:0] REQ_GET_LINE_CODING = 16'hA121;

  localparam logic [31:0] BOOT_TOUCH_BAUD = 32'd1200;
  localparam logic [3:0]  CTRL_EP         = 4'd0;

  localparam int unsigned CODING_BYTES = 7;
  localparam int unsigned BYTE_IDX_W   = $clog2(CODING_BYTES);
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(CODING_BYTES - 1);

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 16;

  // Input item payload, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  new_data_bits;
    logic [7:0]  new_parity;
    logic [7:0]  new_char_format;
    logic [31:0] new_rate;
    logic [7:0]  index_low;
    logic [7:0]  value_low;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
    logic [7:0]  target;
    logic [3:0]  endpoint;
  } item_t;

  typedef struct packed {
    logic [31:0] baud_rate;
    logic [7:0]  stop_bits_code;
    logic [7:0]  parity_code;
    logic [7:0]  data_bits_count;
  } coding_t;

  typedef struct packed {
    coding_t    coding;
    logic [7:0] line_state;
    logic       coding_pending;
  } ctl_state_t;

  typedef struct packed {
    logic        handled;
    reply_kind_t kind;
    logic [7:0]  reply_byte;
    logic        boot_req;
    logic        last;
  } result_t;

endpackage

// ----- rtl/core/usb_cdc_acm_control_requests.sv -----
// ----------------------------------------------------------------------------
// usb_cdc_acm_control_requests
// Control-interface request handler of a CDC ACM serial function.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                          | payload
//  --------+-----------+--------------------------------+------------------------
//  in      | slave     | in_tvalid/in_tready            | tuser: op, tdata: event
//  out     | master    | out_tvalid/out_tready/tlast    | tuser: reply_kind
//  cfg     | write     | cfg_we/cfg_wdata               | control_interface
//
//  An event is held in an input register while its results are formed; each
//  result goes to an output register. One-result events move at one
//  transaction per cycle while the output is not stalled; GET_LINE_CODING holds
//  the input register while the byte counter steps through its seven reply bytes.
//  rst_n is synchronous and active low; it clears the line coding, line state,
//  pending mark and interface number. A stalled output holds its result and
//  the held event, and the input takes a new transaction once the held event
//  has issued its last result.
// ----------------------------------------------------------------------------
module usb_cdc_acm_control_requests (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_wdata,
  // event input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ucdc_pkg::IN_DATA_W-1:0]   in_tdata,  // endpoint, target, request_type,
                                                      // request_code, value_low,
                                                      // index_low, new_rate,
                                                      // new_char_format, new_parity,
                                                      // new_data_bits, zero fill
  input  logic [1:0]                       in_tuser,  // op
  // result output
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ucdc_pkg::OUT_DATA_W-1:0]  out_tdata, // handled, reply_byte,
                                                      // bootloader_request, zero fill
  output logic [1:0]                       out_tuser, // reply_kind
  output logic                             out_tlast
);
  import ucdc_pkg::*;

  // Configuration register
  logic [7:0] ctrl_if_r;

  // Held event
  logic       hold_vld_r;
  logic [1:0] hold_op_r;
  item_t      hold_item_r;
  logic [BYTE_IDX_W-1:0] byte_idx_r;

  // Function state
  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // Output register
  logic       res_vld_r;
  result_t    res_r;

  result_t    cur_res;
  logic       res_free;
  logic       step;
  logic       pop;

  ucdc_req_dec u_dec (
    .op        (hold_op_r),
    .item      (hold_item_r),
    .ctrl_if   (ctrl_if_r),
    .state     (state_r),
    .byte_idx  (byte_idx_r),
    .result    (cur_res),
    .state_nxt (state_nxt)
  );

  // Advance when the output register is empty or being drained
  assign res_free  = !res_vld_r || out_tready;
  assign step      = hold_vld_r && res_free;
  assign pop       = step && cur_res.last;
  assign in_tready = !hold_vld_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_if_r <= 8'd0;
    end else if (cfg_we) begin
      ctrl_if_r <= cfg_wdata;
    end
  end

  // Input register: load a new transaction, drop the event after its last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      byte_idx_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        hold_vld_r <= 1'b1;
      end else if (pop) begin
        hold_vld_r <= 1'b0;
      end
      if (pop) begin
        byte_idx_r <= '0;
      end else if (step) begin
        byte_idx_r <= byte_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_op_r   <= in_tuser;
      hold_item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
  end

  // Commit state changes with the result that carries them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= hold_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= cur_res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - 10){1'b0}}, res_r.boot_req, res_r.reply_byte,
                       res_r.handled};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

  // A byte counter past zero only exists while a GET_LINE_CODING is held
  a_idx_held: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_idx_r != '0) |-> hold_vld_r)
    else $error("byte counter advanced with no held event");

  // Reply bytes come back to back until the last one
  a_data_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (out_tuser == RK_DATA) && !out_tlast)
    |=> (out_tvalid && (out_tuser == RK_DATA)))
    else $error("reply byte run broken");

  // Only reply data spans several results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != RK_DATA)) |-> out_tlast)
    else $error("non-data result not marked last");

  // A bootloader request only rides on a handled status packet
  a_boot_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9]) |-> (out_tdata[0] && (out_tuser == RK_STATUS)))
    else $error("bootloader request outside status packet");

endmodule

// ----- rtl/core/ucdc_req_dec.sv -----
// ----------------------------------------------------------------------------
// ucdc_req_dec
// Decodes one held event into its current result and the next function state.
// ----------------------------------------------------------------------------
module ucdc_req_dec (
  input  logic [1:0]                   op,
  input  ucdc_pkg::item_t              item,
  input  logic [7:0]                   ctrl_if,
  input  ucdc_pkg::ctl_state_t         state,
  input  logic [ucdc_pkg::BYTE_IDX_W-1:0] byte_idx,
  output ucdc_pkg::result_t            result,
  output ucdc_pkg::ctl_state_t         state_nxt
);
  import ucdc_pkg::*;

  logic [15:0] sig;
  logic        to_ctrl;
  logic        ep_ctrl;
  logic        was_touch;
  logic [7:0]  coding_byte;

  assign sig       = {item.request_type, item.request_code};
  assign to_ctrl   = (item.index_low == ctrl_if);
  assign ep_ctrl   = (item.endpoint == CTRL_EP) && (item.target == ctrl_if);
  assign was_touch = (state.coding.baud_rate == BOOT_TOUCH_BAUD);

  // Little-endian baud first, then stop bits, parity, data bits
  always_comb begin
    case (byte_idx)
      3'd0:    coding_byte = state.coding.baud_rate[7:0];
      3'd1:    coding_byte = state.coding.baud_rate[15:8];
      3'd2:    coding_byte = state.coding.baud_rate[23:16];
      3'd3:    coding_byte = state.coding.baud_rate[31:24];
      3'd4:    coding_byte = state.coding.stop_bits_code;
      3'd5:    coding_byte = state.coding.parity_code;
      3'd6:    coding_byte = state.coding.data_bits_count;
      default: coding_byte = 8'd0;
    endcase
  end

  always_comb begin
    state_nxt         = state;
    result.handled    = 1'b0;
    result.kind       = RK_NONE;
    result.reply_byte = 8'd0;
    result.boot_req   = 1'b0;
    result.last       = 1'b1;
    unique case (op)
      OP_SETUP: begin
        if (to_ctrl && (sig == REQ_SET_LINE_CODING)) begin
          state_nxt.coding_pending = 1'b1;
          result.handled           = 1'b1;
        end else if (to_ctrl && (sig == REQ_SET_CTRL_LINE)) begin
          state_nxt.line_state = item.value_low;
          result.handled       = 1'b1;
          result.kind          = RK_STATUS;
          result.boot_req      = (item.value_low == 8'd0) && was_touch;
        end else if (to_ctrl && (sig == REQ_GET_LINE_CODING)) begin
          result.handled    = 1'b1;
          result.kind       = RK_DATA;
          result.reply_byte = coding_byte;
          result.last       = (byte_idx == LAST_BYTE_IDX);
        end
      end
      OP_OUT_DATA: begin
        if (ep_ctrl && state.coding_pending) begin
          state_nxt.coding.baud_rate       = item.new_rate;
          state_nxt.coding.stop_bits_code  = item.new_char_format;
          state_nxt.coding.parity_code     = item.new_parity;
          state_nxt.coding.data_bits_count = item.new_data_bits;
          result.handled  = 1'b1;
          result.kind     = RK_STATUS;
          result.boot_req = (item.new_rate == 32'd0) && was_touch;
        end
      end
      OP_IN_DONE: begin
        result.handled = ep_ctrl;
      end
      default: begin
        result.handled = 1'b0;
      end
    endcase
  end

endmodule
